[sv/ufpc_pkg.sv]
// shared types and constants for the union-find engine
// no dependencies; used by ufpc_ctrl, ufpc_dp and union_find_path_compression
package ufpc_pkg;

  localparam int NODE_W = 11;
  localparam int OP_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_JOIN  = 2'd1,
    OP_FIND  = 2'd2
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;   // latch clamped node_a / node_b, start walk at node_a
    logic issue_cur;   // read parent of the current node
    logic walk;        // one step of the root walk
    logic compress;    // one step of path rewrite
    logic next_b;      // keep first root, restart at node_b
    logic link;        // hang first root under second
    logic sweep_clr;   // restart the init sweep
    logic sweep;       // write one self link
    logic out_load;    // load the result register
    logic out_zero;    // result is zero rather than the root
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic root_hit;
    logic start_is_root;
    logic cmp_last;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

[sv/union_find_path_compression.sv]
// Disjoint-set engine with full path compression over a NODES-entry parent
// table held in one simple dual-port ram. After reset the block initializes
// the table, one entry a cycle, and holds in_stall_o high meanwhile. A clear
// item runs the same sweep and then loads a zero result. A find walks up from
// its node with one ram read per link on the way up plus one for the root,
// then rewrites the path with one read and one write per link. A join runs
// both finds and then hangs the first root under the second, and an unused
// operation code loads a zero result without touching the table. A held
// result delays the load. The next item is taken in the cycle after a result
// is loaded. The parent table has a single read port; one item is in flight
// at a time and the result register lets the next item enter while a result
// waits.
// depends on ufpc_pkg, ufpc_ctrl, ufpc_dp, ufpc_ram
module union_find_path_compression #(
  parameter int NODES = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ufpc_pkg::OP_W-1:0]     operation_i,
  input  logic [ufpc_pkg::NODE_W-1:0]   node_a_i,
  input  logic [ufpc_pkg::NODE_W-1:0]   node_b_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ufpc_pkg::NODE_W-1:0]   representative_o
);

  ufpc_pkg::cmd_t cmd;
  ufpc_pkg::sts_t sts;

  ufpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .operation_i(operation_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ufpc_dp #(
    .NODES(NODES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .node_a_i        (node_a_i),
    .node_b_i        (node_b_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .representative_o(representative_o)
  );

  // one item at a time: an accepted beat always makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in flight");

  // a result never overwrites one that is still held
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && out_stall_i))
    else $error("result register loaded while stalled");

  // the table is never rewritten while idle
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !(cmd.compress || cmd.link || cmd.sweep))
    else $error("parent table written while idle");

  // a clear beat starts the sweep and produces no early result
  a_clear_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && operation_i == ufpc_pkg::OP_CLEAR |=> cmd.sweep)
    else $error("clear did not start the table sweep");

endmodule

[sv/ufpc_ram.sv]
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module ufpc_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/ufpc_ctrl.sv]
// sequencer for clear sweep, root walk, path rewrite and link
// depends on ufpc_pkg (cmd_t, sts_t, op_e)
module ufpc_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [ufpc_pkg::OP_W-1:0]      operation_i,
  output logic                           in_stall_o,
  input  ufpc_pkg::sts_t                 sts_i,
  output ufpc_pkg::cmd_t                 cmd_o
);

  typedef enum logic [7:0] {
    S_SWEEP = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_START = 8'b0000_0100,
    S_WALK  = 8'b0000_1000,
    S_CMP   = 8'b0001_0000,
    S_FOUND = 8'b0010_0000,
    S_LINK  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   join_q, join_d;
  logic   second_q, second_d;
  logic   zero_q, zero_d;
  logic   report_q, report_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d  = state_q;
    join_d   = join_q;
    second_d = second_q;
    zero_d   = zero_q;
    report_d = report_q;
    cmd_o    = '0;
    cmd_o.out_zero = zero_q;

    case (state_q)
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = report_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          second_d = 1'b0;
          case (operation_i)
            ufpc_pkg::OP_CLEAR: begin
              cmd_o.sweep_clr = 1'b1;
              zero_d   = 1'b1;
              report_d = 1'b1;
              state_d  = S_SWEEP;
            end
            ufpc_pkg::OP_JOIN: begin
              cmd_o.load_item = 1'b1;
              join_d  = 1'b1;
              zero_d  = 1'b0;
              state_d = S_START;
            end
            ufpc_pkg::OP_FIND: begin
              cmd_o.load_item = 1'b1;
              join_d  = 1'b0;
              zero_d  = 1'b0;
              state_d = S_START;
            end
            default: begin
              // unused code: no table change, zero result
              zero_d  = 1'b1;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_START: begin
        cmd_o.issue_cur = 1'b1;
        state_d = S_WALK;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.root_hit) begin
          state_d = sts_i.start_is_root ? S_FOUND : S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.compress = 1'b1;
        if (sts_i.cmp_last) begin
          state_d = S_FOUND;
        end
      end
      S_FOUND: begin
        if (join_q && !second_q) begin
          cmd_o.next_b = 1'b1;
          second_d = 1'b1;
          state_d  = S_START;
        end else if (join_q) begin
          state_d = S_LINK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_LINK: begin
        cmd_o.link = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_SWEEP;
      join_q   <= 1'b0;
      second_q <= 1'b0;
      zero_q   <= 1'b0;
      report_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      join_q   <= join_d;
      second_q <= second_d;
      zero_q   <= zero_d;
      report_q <= report_d;
    end
  end

endmodule

[sv/ufpc_dp.sv]
// parent table, walk registers, sweep counter and result register
// depends on ufpc_pkg and ufpc_ram
module ufpc_dp #(
  parameter int NODES = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ufpc_pkg::cmd_t                cmd_i,
  output ufpc_pkg::sts_t                sts_o,
  input  logic [ufpc_pkg::NODE_W-1:0]   node_a_i,
  input  logic [ufpc_pkg::NODE_W-1:0]   node_b_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ufpc_pkg::NODE_W-1:0]   representative_o
);

  localparam int AW = $clog2(NODES);
  localparam int NW = ufpc_pkg::NODE_W;
  localparam logic [AW-1:0] LAST = AW'(NODES - 1);

  logic [NW-1:0] a_clamp, b_clamp;
  logic [NW-1:0] b_q, start_q, cur_q, root_q, ra_q;
  logic [NW-1:0] rdata, rnode;
  logic [NW-1:0] wnode, wdata;
  logic [AW-1:0] sweep_q;
  logic          we;
  logic          out_valid_q;
  logic [NW-1:0] rep_q;

  // indices beyond the table fold onto the last entry
  assign a_clamp = (32'(node_a_i) >= NODES) ? NW'(NODES - 1) : node_a_i;
  assign b_clamp = (32'(node_b_i) >= NODES) ? NW'(NODES - 1) : node_b_i;

  always_comb begin
    if (cmd_i.walk) begin
      rnode = (rdata == cur_q) ? start_q : rdata;
    end else if (cmd_i.compress) begin
      rnode = rdata;
    end else begin
      rnode = cur_q;
    end
  end

  always_comb begin
    we    = cmd_i.sweep || cmd_i.compress || cmd_i.link;
    wnode = cur_q;
    wdata = root_q;
    if (cmd_i.link) begin
      wnode = ra_q;
    end
  end

  ufpc_ram #(
    .WIDTH(NW),
    .DEPTH(NODES)
  ) u_parent (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cmd_i.sweep ? sweep_q : AW'(wnode)),
    .wdata_i(cmd_i.sweep ? NW'(sweep_q) : wdata),
    .raddr_i(AW'(rnode)),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      b_q     <= b_clamp;
      start_q <= a_clamp;
      cur_q   <= a_clamp;
    end else if (cmd_i.next_b) begin
      ra_q    <= root_q;
      start_q <= b_q;
      cur_q   <= b_q;
    end else if (cmd_i.walk) begin
      if (rdata == cur_q) begin
        root_q <= cur_q;
        cur_q  <= start_q;
      end else begin
        cur_q  <= rdata;
      end
    end else if (cmd_i.compress) begin
      cur_q <= rdata;
    end
    if (cmd_i.out_load) begin
      rep_q <= cmd_i.out_zero ? '0 : root_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.sweep_clr || (cmd_i.sweep && sweep_q == LAST)) begin
        sweep_q <= '0;
      end else if (cmd_i.sweep) begin
        sweep_q <= sweep_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.root_hit      = (rdata == cur_q);
  assign sts_o.start_is_root = (start_q == cur_q);
  assign sts_o.cmp_last      = (rdata == root_q);
  assign sts_o.sweep_last    = (sweep_q == LAST);
  assign sts_o.out_free      = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign representative_o = rep_q;

endmodule
